// ----- rtl/srec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_pkg
// Types, character constants and hex decode shared by the S-record loader.
// ----------------------------------------------------------------------------
package srec_pkg;

  localparam int unsigned MemSizeW   = 30;
  localparam int unsigned PhysAddrW  = 29;
  localparam int unsigned SrcAddrW   = 32;

  localparam logic [MemSizeW-1:0] MemSizeReset = 30'd16777216;

  localparam logic [7:0] ChS       = 8'h53; // 'S'
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam logic [7:0] MinS3Count = 8'd5;

  // kseg0 / kseg1 windows, selected by the top three address bits
  localparam logic [2:0] Kseg0Top = 3'b100;
  localparam logic [2:0] Kseg1Top = 3'b101;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ERR_TYPE  = 2'd0,
    ERR_COUNT = 2'd1,
    ERR_ADDR  = 2'd2,
    ERR_DATA  = 2'd3
  } error_code_e;

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_COUNT = 6'b000100,
    PH_ADDR  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_payload_t;

  typedef struct packed {
    result_kind_e           result_kind;
    logic [PhysAddrW-1:0]   write_address;
    logic [7:0]             write_data;
    logic [SrcAddrW-1:0]    entry_address;
    error_code_e            error_code;
  } out_payload_t;

  // input register -> parser
  typedef struct packed {
    logic        valid;
    in_payload_t beat;
  } in_stage_t;

  // parser -> output register
  typedef struct packed {
    logic         valid;
    out_payload_t beat;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;   // 'a'/'A' low nibble is 1
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/srec_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface srec_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/srec_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_in_stage
// Input register: holds one character beat for the parser.
// ----------------------------------------------------------------------------
module srec_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  srec_pkg::in_payload_t beat_i,
  input  logic                  take_i,
  output srec_pkg::in_stage_t   stage_o
);
  import srec_pkg::*;

  logic        valid_q, valid_d;
  in_payload_t beat_q;
  logic        load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;

endmodule

// ----- rtl/srec_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_parser
// Record state machine: one character step per cycle unless a result must wait for
// space in the output register; yields at most one result per character.
// ----------------------------------------------------------------------------
module srec_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              memory_size_we_i,
  input  logic [srec_pkg::MemSizeW-1:0]     memory_size_i,
  input  srec_pkg::in_stage_t               stage_i,
  input  logic                              out_space_i,
  output logic                              take_o,
  output srec_pkg::result_t                 result_o
);
  import srec_pkg::*;

  phase_e                phase_q, phase_d;
  logic                  halted_q, halted_d;
  logic                  is_s7_q, is_s7_d;
  logic [3:0]            nibble_q, nibble_d;
  logic [2:0]            digit_q, digit_d;
  logic [SrcAddrW-1:0]   acc_q, acc_d;
  logic [7:0]            left_q, left_d;
  logic [MemSizeW-1:0]   mem_size_q;

  logic        eoi;
  logic [7:0]  ch;
  hex_t        hx;
  logic        hex_ok;
  logic [7:0]  count;
  logic [7:0]  left_dec;
  logic [SrcAddrW-1:0] acc_shift;
  logic        in_window;
  logic [PhysAddrW-1:0] phys;
  result_t     res;

  assign eoi       = stage_i.beat.end_of_input;
  assign ch        = stage_i.beat.character;
  assign hx        = hex_decode(ch);
  assign hex_ok    = !eoi && hx.ok;
  assign count     = {nibble_q, hx.value};
  assign left_dec  = left_q - 8'd1;
  assign acc_shift = {acc_q[SrcAddrW-5:0], hx.value};
  assign in_window = (acc_q[31:29] == Kseg0Top) || (acc_q[31:29] == Kseg1Top);
  assign phys      = acc_q[PhysAddrW-1:0];

  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    is_s7_d  = is_s7_q;
    nibble_d = nibble_q;
    digit_d  = digit_q;
    acc_d    = acc_q;
    left_d   = left_q;
    res      = '0;

    if (!halted_q) begin
      unique case (phase_q)
        PH_START: begin
          if (!eoi) begin
            if (ch != ChS) begin
              res.valid            = 1'b1;
              res.beat.result_kind = KIND_ERROR;
              res.beat.error_code  = ERR_TYPE;
            end else begin
              phase_d = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          if (!eoi && ch >= ChZero && ch <= ChNine && ch[3:0] == 4'd0) begin
            phase_d = PH_SKIP;
          end else if (!eoi && (ch[3:0] == 4'd3 || ch[3:0] == 4'd7)
                       && ch[7:4] == ChZero[7:4]) begin
            is_s7_d = ch[2];
            digit_d = 3'd0;
            phase_d = PH_COUNT;
          end else begin
            res.valid            = 1'b1;
            res.beat.result_kind = KIND_ERROR;
            res.beat.error_code  = ERR_TYPE;
          end
        end
        PH_COUNT: begin
          if (!hex_ok) begin
            res.valid            = 1'b1;
            res.beat.result_kind = KIND_ERROR;
            res.beat.error_code  = ERR_COUNT;
          end else if (digit_q == 3'd0) begin
            nibble_d = hx.value;
            digit_d  = 3'd1;
          end else if (!is_s7_q && count < MinS3Count) begin
            res.valid            = 1'b1;
            res.beat.result_kind = KIND_ERROR;
            res.beat.error_code  = ERR_COUNT;
          end else begin
            left_d  = is_s7_q ? 8'd0 : count - MinS3Count;
            digit_d = 3'd0;
            acc_d   = '0;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (!hex_ok) begin
            res.valid            = 1'b1;
            res.beat.result_kind = KIND_ERROR;
            res.beat.error_code  = ERR_ADDR;
          end else begin
            acc_d = acc_shift;
            if (digit_q != 3'd7) begin
              digit_d = digit_q + 3'd1;
            end else begin
              digit_d = 3'd0;
              if (is_s7_q) begin
                phase_d                = PH_SKIP;
                res.valid              = 1'b1;
                res.beat.result_kind   = KIND_ENTRY;
                res.beat.entry_address = acc_shift;
              end else begin
                phase_d = (left_q == 8'd0) ? PH_SKIP : PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          if (!hex_ok) begin
            res.valid            = 1'b1;
            res.beat.result_kind = KIND_ERROR;
            res.beat.error_code  = ERR_DATA;
          end else if (digit_q == 3'd0) begin
            nibble_d = hx.value;
            digit_d  = 3'd1;
          end else begin
            digit_d = 3'd0;
            acc_d   = acc_q + 32'd1;
            left_d  = left_dec;
            if (left_dec == 8'd0) begin
              phase_d = PH_SKIP;
            end
            // dropped when unmapped or past the end of memory
            if (in_window && ({1'b0, phys} < mem_size_q)) begin
              res.valid              = 1'b1;
              res.beat.result_kind   = KIND_WRITE;
              res.beat.write_address = phys;
              res.beat.write_data    = count;
            end
          end
        end
        PH_SKIP: begin
          if (eoi || ch == ChNewline) begin
            phase_d = PH_START;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
      if (res.valid && res.beat.result_kind == KIND_ERROR) begin
        halted_d = 1'b1;
      end
    end
  end

  // a character with no result need not wait for the output register
  assign take_o   = stage_i.valid && (out_space_i || !res.valid);
  assign result_o = '{valid: take_o && res.valid, beat: res.beat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      halted_q <= 1'b0;
      is_s7_q  <= 1'b0;
      nibble_q <= 4'd0;
      digit_q  <= 3'd0;
      acc_q    <= '0;
      left_q   <= 8'd0;
    end else if (take_o) begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
      is_s7_q  <= is_s7_d;
      nibble_q <= nibble_d;
      digit_q  <= digit_d;
      acc_q    <= acc_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MemSizeReset;
    end else if (memory_size_we_i) begin
      mem_size_q <= memory_size_i;
    end
  end

endmodule

// ----- rtl/srec_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module srec_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  srec_pkg::result_t      result_i,
  output logic                   space_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output srec_pkg::out_payload_t beat_o
);
  import srec_pkg::*;

  logic         valid_q, valid_d;
  out_payload_t beat_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = space_o ? result_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && result_i.valid) begin
      beat_q <= result_i.beat;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ----- rtl/srecord_loader.sv -----
`timescale 1ns / 1ps
// A character goes from the input register through the parser to the result register.
// Throughput: one character per cycle; the input register, the one-step parser and
// the result register move together, and stall only when a result waits at the output.
// Reset (rst_ni low, asynchronous): parser waits for 'S', not halted, both beat
// registers empty, memory size back to 16 MiB.
// ----------------------------------------------------------------------------
// srecord_loader
// S-record (S0/S3/S7) character stream to byte writes, entry address and error results.
// ----------------------------------------------------------------------------
module srecord_loader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  srec_chan_if.sink                     in_i,
  srec_chan_if.source                   out_o,
  input  logic                          memory_size_we_i,
  input  logic [srec_pkg::MemSizeW-1:0] memory_size_i
);
  import srec_pkg::*;

  in_stage_t    stage;
  result_t      result;
  logic         take;
  logic         out_space;
  out_payload_t out_beat;

  srec_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .beat_i  (in_i.payload),
    .take_i  (take),
    .stage_o (stage)
  );

  srec_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .memory_size_we_i (memory_size_we_i),
    .memory_size_i    (memory_size_i),
    .stage_i          (stage),
    .out_space_i      (out_space),
    .take_o           (take),
    .result_o         (result)
  );

  srec_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .result_i (result),
    .space_o  (out_space),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .beat_o   (out_beat)
  );

  assign out_o.payload = out_beat;

endmodule

// ----- rtl/srec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_checker
// Port-level checks on the loader's result channel.
// ----------------------------------------------------------------------------
module srec_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input srec_pkg::out_payload_t        out_beat_i,
  input logic                          memory_size_we_i,
  input logic [srec_pkg::MemSizeW-1:0] memory_size_i
);
  import srec_pkg::*;

  logic                seen_err_q;
  logic [MemSizeW-1:0] mem_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_err_q <= 1'b0;
      mem_size_q <= MemSizeReset;
    end else begin
      if (out_valid_i && out_ready_i && out_beat_i.result_kind == KIND_ERROR) begin
        seen_err_q <= 1'b1;
      end
      if (memory_size_we_i) begin
        mem_size_q <= memory_size_i;
      end
    end
  end

  // result register is empty in the cycle after any cycle spent in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result beat shown during reset");

  // an error halts the loader: nothing follows it
  a_halt_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_err_q |-> !out_valid_i)
    else $error("result beat after an error beat");

  a_write_in_memory: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_beat_i.result_kind == KIND_WRITE)
      |-> ({1'b0, out_beat_i.write_address} < mem_size_q))
    else $error("byte write beyond memory size");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_beat_i.result_kind == KIND_WRITE ||
                     out_beat_i.result_kind == KIND_ENTRY ||
                     out_beat_i.result_kind == KIND_ERROR))
    else $error("undefined result kind");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_beat_i)))
    else $error("stalled result beat changed");

endmodule

bind srecord_loader srec_checker u_srec_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_beat_i       (out_o.payload),
  .memory_size_we_i (memory_size_we_i),
  .memory_size_i    (memory_size_i)
);

// ----- dv/tb_srecord_loader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srecord_loader
// Feeds S-record text one character per beat and checks every byte write,
// entry address and error beat against an in-bench parser model. A short
// scripted opening, random well-formed records under several memory sizes,
// then one broken record chosen at random and trailing noise while halted.
// ----------------------------------------------------------------------------
module tb_srecord_loader;
  import srec_pkg::*;

  localparam logic [7:0]  CharS      = "S";
  localparam logic [7:0]  CharLf     = 8'h0a;
  localparam logic [7:0]  CharZero   = "0";
  localparam logic [7:0]  CharNine   = "9";
  localparam logic [3:0]  RecHeader  = 4'd0;
  localparam logic [3:0]  RecData32  = 4'd3;
  localparam logic [3:0]  RecEntry32 = 4'd7;
  localparam logic [7:0]  MinDataCount = 8'd5;
  localparam logic [31:0] Kseg0Lo = 32'h8000_0000;
  localparam logic [31:0] Kseg0Hi = 32'h9fff_ffff;
  localparam logic [31:0] Kseg1Lo = 32'ha000_0000;
  localparam logic [31:0] Kseg1Hi = 32'hbfff_ffff;
  localparam logic [29:0] MemSizeMax = 30'd536870912;
  localparam int          PhaseChars = 140;

  typedef struct {
    string        text;
    bit           eoi;    // end of input after the text
    bit           typed;  // the one result of the row is given below
    result_kind_e kind;
    logic [28:0]  waddr;
    logic [7:0]   wdata;
    logic [31:0]  entry;
    error_code_e  code;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic memory_size_we;
  logic [MemSizeW-1:0] memory_size_val;

  srec_chan_if #(.payload_t(in_payload_t))  in_ch ();
  srec_chan_if #(.payload_t(out_payload_t)) out_ch ();

  srecord_loader dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_i             (in_ch),
    .out_o            (out_ch),
    .memory_size_we_i (memory_size_we),
    .memory_size_i    (memory_size_val)
  );

  always #1 clk = ~clk;

  // parser model state
  phase_e      ph        = PH_START;
  logic [3:0]  rtype     = '0;
  logic [3:0]  hi_nib    = '0;
  logic [2:0]  dig       = '0;
  logic [31:0] addr_acc  = '0;
  logic [7:0]  bytes_left = '0;
  bit          halted    = 1'b0;
  logic [29:0] mem_size  = MemSizeReset;

  out_payload_t due_results [$];
  int  bad_beats = 0;
  int  chars_sent = 0;
  bit  no_gaps = 1'b0;

  script_row_t opening [10] = '{
    '{"",                    1'b1, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S00F0000hdr\n",       1'b0, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S3068000000000C3\n",  1'b0, 1'b1, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S306a0FFFFFFfF01\n",  1'b0, 1'b1, KIND_WRITE, 29'h0ff_ffff,  8'hff, 32'h0, ERR_TYPE},
    '{"S306A100000055\n",    1'b0, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S30500000000FA\n",    1'b0, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S3077FFFFFFF1234\n",  1'b0, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S307FFFFFFFF0102\n",  1'b0, 1'b0, KIND_WRITE, 29'h0,         8'h00, 32'h0, ERR_TYPE},
    '{"S700BFC00000\n",      1'b0, 1'b1, KIND_ENTRY, 29'h0,         8'h00, 32'hbfc0_0000,
      ERR_TYPE},
    '{"S705FFFFFFFF",        1'b1, 1'b1, KIND_ENTRY, 29'h0,         8'h00, 32'hffff_ffff,
      ERR_TYPE}
  };

  // each of these halts the parser; one is picked per run
  script_row_t breakers [10] = '{
    '{"\n",              1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_TYPE},
    '{"S",               1'b1, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_TYPE},
    '{"S5",              1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_TYPE},
    '{"Sx",              1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_TYPE},
    '{"S304",            1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_COUNT},
    '{"S3g",             1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_COUNT},
    '{"S70",             1'b1, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_COUNT},
    '{"S30680G",         1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_ADDR},
    '{"S30700000000AAz", 1'b0, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_DATA},
    '{"S3070000000012",  1'b1, 1'b1, KIND_ERROR, 29'h0, 8'h00, 32'h0, ERR_DATA}
  };

  function automatic int nibble_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch - "0";
    if (ch >= "a" && ch <= "f") return ch - "a" + 10;
    if (ch >= "A" && ch <= "F") return ch - "A" + 10;
    return -1;
  endfunction

  function automatic bit raise(input error_code_e code, output out_payload_t res);
    halted = 1'b1;
    res = '0;
    res.result_kind = KIND_ERROR;
    res.error_code  = code;
    return 1'b1;
  endfunction

  // one character through the parser model; 1 when it yields a result
  function automatic bit decode_char(input logic [7:0] ch, input bit eoi,
                                     output out_payload_t res);
    int          h;
    logic [7:0]  cnt;
    logic [31:0] a;
    logic [31:0] phys;
    bit          mapped;
    res = '0;
    if (halted) return 1'b0;
    h = eoi ? -1 : nibble_of(ch);
    case (ph)
      PH_START: begin
        if (eoi) return 1'b0;
        if (ch != CharS) return raise(ERR_TYPE, res);
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        if (eoi || ch < CharZero || ch > CharNine) return raise(ERR_TYPE, res);
        rtype = 4'(ch - CharZero);
        if (rtype == RecHeader) begin
          ph = PH_SKIP;
        end else if (rtype == RecData32 || rtype == RecEntry32) begin
          dig = '0;
          ph  = PH_COUNT;
        end else begin
          return raise(ERR_TYPE, res);
        end
      end
      PH_COUNT: begin
        if (h < 0) return raise(ERR_COUNT, res);
        if (dig == 0) begin
          hi_nib = h[3:0];
          dig    = 3'd1;
        end else begin
          cnt = {hi_nib, h[3:0]};
          if (rtype == RecData32) begin
            if (cnt < MinDataCount) return raise(ERR_COUNT, res);
            bytes_left = cnt - MinDataCount;
          end else begin
            bytes_left = '0;   // S7 count is not checked
          end
          dig      = '0;
          addr_acc = '0;
          ph       = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (h < 0) return raise(ERR_ADDR, res);
        addr_acc = {addr_acc[27:0], h[3:0]};
        if (dig < 3'd7) begin
          dig++;
        end else begin
          dig = '0;
          if (rtype == RecEntry32) begin
            ph = PH_SKIP;
            res.result_kind   = KIND_ENTRY;
            res.entry_address = addr_acc;
            return 1'b1;
          end
          ph = (bytes_left == 0) ? PH_SKIP : PH_DATA;
        end
      end
      PH_DATA: begin
        if (h < 0) return raise(ERR_DATA, res);
        if (dig == 0) begin
          hi_nib = h[3:0];
          dig    = 3'd1;
        end else begin
          dig      = '0;
          a        = addr_acc;
          addr_acc = a + 32'd1;
          bytes_left--;
          if (bytes_left == 0) ph = PH_SKIP;
          mapped = 1'b1;
          phys   = '0;
          if (a >= Kseg0Lo && a <= Kseg0Hi) begin
            phys = a - Kseg0Lo;
          end else if (a >= Kseg1Lo && a <= Kseg1Hi) begin
            phys = a - Kseg1Lo;
          end else begin
            mapped = 1'b0;
          end
          if (!mapped || phys >= {2'b00, mem_size}) return 1'b0;
          res.result_kind   = KIND_WRITE;
          res.write_address = phys[28:0];
          res.write_data    = {hi_nib, h[3:0]};
          return 1'b1;
        end
      end
      PH_SKIP: begin
        if (eoi || ch == CharLf) ph = PH_START;
      end
      default: ph = PH_START;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CharZero + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CharLf);
    return c;
  endfunction

  function automatic logic [31:0] pick_address();
    logic [31:0] win;
    win = $urandom_range(0, 1) ? Kseg0Lo : Kseg1Lo;
    case ($urandom_range(0, 4))
      0:       return win + 32'($urandom_range(0, 63));
      1:       return win + {2'b00, mem_size} - 32'($urandom_range(0, 8)); // memory bound
      2:       return win + 32'h1fff_fff8 + 32'($urandom_range(0, 7));     // window top
      3:       return Kseg0Lo - 32'($urandom_range(1, 8));
      default: return $urandom;
    endcase
  endfunction

  task automatic feed_char(input logic [7:0] ch, input bit eoi,
                           input bit typed = 1'b0, input out_payload_t want = '0);
    int           gap;
    out_payload_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                  <= 1'b1;
    in_ch.payload.character      <= ch;
    in_ch.payload.end_of_input   <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    if (decode_char(ch, eoi, res)) due_results.push_back(typed ? want : res);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    feed_char(hex_char(b[7:4]), 1'b0);
    feed_char(hex_char(b[3:0]), 1'b0);
  endtask

  task automatic run_row(input script_row_t r);
    out_payload_t want;
    want = '0;
    want.result_kind   = r.kind;
    want.write_address = r.waddr;
    want.write_data    = r.wdata;
    want.entry_address = r.entry;
    want.error_code    = r.code;
    for (int i = 0; i < r.text.len(); i++) feed_char(r.text[i], 1'b0, r.typed, want);
    if (r.eoi) feed_char(8'($urandom), 1'b1, r.typed, want);
  endtask

  task automatic emit_record();
    int          pick;
    int          nbytes;
    logic [31:0] addr;
    no_gaps = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 19) == 0) feed_char(8'($urandom), 1'b1);
    pick = $urandom_range(0, 9);
    feed_char(CharS, 1'b0);
    if (pick == 0) begin
      feed_char("0", 1'b0);
      repeat ($urandom_range(0, 12)) feed_char(any_but_lf(), 1'b0);
    end else begin
      if (pick == 1) begin
        feed_char("7", 1'b0);
        feed_byte(8'($urandom));
        addr = $urandom_range(0, 1) ? pick_address() : $urandom;
        nbytes = 0;
      end else begin
        nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 250) : $urandom_range(0, 8);
        feed_char("3", 1'b0);
        feed_byte(8'(nbytes + 5));
        addr = pick_address();
      end
      for (int k = 3; k >= 0; k--) feed_byte(addr[8*k +: 8]);
      repeat (nbytes) feed_byte(8'($urandom));
    end
    feed_byte(8'($urandom));   // checksum, ignored
    repeat ($urandom_range(0, 3)) feed_char(any_but_lf(), 1'b0);
    if ($urandom_range(0, 9) == 0) feed_char(8'($urandom), 1'b1);
    else feed_char(CharLf, 1'b0);
  endtask

  task automatic set_mem_size(input logic [29:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // characters with no result may still be in flight
    memory_size_we  <= 1'b1;
    memory_size_val <= v;
    @(posedge clk);
    memory_size_we <= 1'b0;
    mem_size = v;
  endtask

  // result side: random stall before each beat
  initial begin : sink_side
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_beat
    out_payload_t head;
    if (out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing due: result_kind %0d", out_ch.payload.result_kind);
        bad_beats++;
      end else begin
        head = due_results.pop_front();
        if (out_ch.payload.result_kind !== head.result_kind) begin
          $error("result_kind: expected %0d, got %0d", head.result_kind,
                 out_ch.payload.result_kind);
          bad_beats++;
        end
        if (out_ch.payload.write_address !== head.write_address) begin
          $error("write_address: expected %h, got %h", head.write_address,
                 out_ch.payload.write_address);
          bad_beats++;
        end
        if (out_ch.payload.write_data !== head.write_data) begin
          $error("write_data: expected %h, got %h", head.write_data,
                 out_ch.payload.write_data);
          bad_beats++;
        end
        if (out_ch.payload.entry_address !== head.entry_address) begin
          $error("entry_address: expected %h, got %h", head.entry_address,
                 out_ch.payload.entry_address);
          bad_beats++;
        end
        if (out_ch.payload.error_code !== head.error_code) begin
          $error("error_code: expected %0d, got %0d", head.error_code,
                 out_ch.payload.error_code);
          bad_beats++;
        end
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [29:0] sizes [5];
    int          target;
    rst_n           = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.payload   <= '0;
    memory_size_we  <= 1'b0;
    memory_size_val <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening[i]) run_row(opening[i]);

    sizes = '{30'd0, MemSizeMax, 30'($urandom_range(1, 536870911)), 30'd1, MemSizeReset};
    foreach (sizes[p]) begin
      set_mem_size(sizes[p]);
      target = chars_sent + PhaseChars;
      while (chars_sent < target) emit_record();
    end

    // broken record, then noise that a halted parser must ignore
    no_gaps = 1'b0;
    run_row(breakers[$urandom_range(0, 9)]);
    repeat (24) feed_char(8'($urandom), $urandom_range(0, 3) == 0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
